// ----- src/cbi_pkg.sv -----
// Shared types and constants for the convolutional byte interleaver.
// Used by every module of the block; depends on nothing.
package cbi_pkg;

  localparam int unsigned BRANCHES_DEF   = 12;
  localparam int unsigned UNIT_DEPTH_DEF = 12;
  localparam int unsigned DATA_W         = 8;

  localparam int unsigned FIFO_DEPTH = 3;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 2;

  typedef logic [DATA_W-1:0] byte_t;

  typedef struct packed {
    logic bypass;  // branch zero, no storage access
    logic zero;    // slot not yet written since reset
  } cbi_req_t;

endpackage

// ----- src/cbi_addr_gen.sv -----
// Branch sequencer: branch counter, branch base and length, per-branch slot pointers
// and fill flags. Produces the store address for each item. Depends on cbi_pkg.
module cbi_addr_gen #(
  parameter int unsigned BRANCHES   = cbi_pkg::BRANCHES_DEF,
  parameter int unsigned UNIT_DEPTH = cbi_pkg::UNIT_DEPTH_DEF,
  parameter int unsigned ADDR_W     = 10,
  parameter int unsigned LEN_W      = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  output logic [ADDR_W-1:0] addr_o,
  output cbi_pkg::cbi_req_t req_o
);

  localparam int unsigned BIDX_W = $clog2(BRANCHES);

  logic [BIDX_W-1:0] branch_q, branch_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  slot_q [BRANCHES];
  logic [BRANCHES-1:0] filled_q;

  logic [LEN_W-1:0] cur_slot;
  logic [LEN_W-1:0] slot_inc;
  logic             slot_wrap;
  logic             last_branch;

  always_comb begin
    cur_slot    = slot_q[branch_q];
    slot_inc    = cur_slot + LEN_W'(1);
    slot_wrap   = (slot_inc == len_q);
    last_branch = (branch_q == BIDX_W'(BRANCHES - 1));
    addr_o      = base_q + ADDR_W'(cur_slot);
    req_o.bypass = (branch_q == '0);
    req_o.zero   = ~filled_q[branch_q];
    if (last_branch) begin
      branch_d = '0;
      base_d   = '0;
      len_d    = '0;
    end else begin
      branch_d = branch_q + BIDX_W'(1);
      base_d   = base_q + ADDR_W'(len_q);
      len_d    = len_q + LEN_W'(UNIT_DEPTH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      branch_q <= '0;
      base_q   <= '0;
      len_q    <= '0;
      filled_q <= '0;
      for (int i = 0; i < BRANCHES; i++) begin
        slot_q[i] <= '0;
      end
    end else if (step_i) begin
      branch_q <= branch_d;
      base_q   <= base_d;
      len_q    <= len_d;
      if (branch_q != '0) begin
        slot_q[branch_q] <= slot_wrap ? '0 : slot_inc;
        if (slot_wrap) begin
          filled_q[branch_q] <= 1'b1;
        end
      end
    end
  end

  a_branch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    branch_q <= BIDX_W'(BRANCHES - 1))
    else $error("branch counter out of range");

  a_branch0_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (branch_q == '0) |-> (base_q == '0 && len_q == '0))
    else $error("base or length not cleared at branch zero");

  a_slot_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (branch_q != '0) |-> (cur_slot < len_q))
    else $error("slot pointer beyond branch length");

  a_filled_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && branch_q != '0 && slot_wrap) |=> filled_q[$past(branch_q)])
    else $error("fill flag not set after wrap");

endmodule

// ----- src/cbi_store.sv -----
// Delay line storage for all branches: single-port, read-first synchronous RAM.
// Depends on cbi_pkg.
module cbi_store #(
  parameter int unsigned DEPTH  = 792,
  parameter int unsigned ADDR_W = 10
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [ADDR_W-1:0]   addr_i,
  input  cbi_pkg::byte_t      wdata_i,
  output cbi_pkg::byte_t      rdata_o
);

  cbi_pkg::byte_t mem [DEPTH];
  cbi_pkg::byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/cbi_out_fifo.sv -----
// Three-entry output queue that decouples the RAM read stage from the output handshake.
// Depends on cbi_pkg.
module cbi_out_fifo (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  cbi_pkg::byte_t                     data_i,
  input  logic                               pop_i,
  output logic                               valid_o,
  output cbi_pkg::byte_t                     data_o,
  output logic [cbi_pkg::FIFO_CNT_W-1:0]     count_o
);

  cbi_pkg::byte_t entry_q [cbi_pkg::FIFO_DEPTH];
  logic [cbi_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [cbi_pkg::FIFO_CNT_W-1:0] cnt_q;

  function automatic logic [cbi_pkg::FIFO_PTR_W-1:0] ptr_next(
    input logic [cbi_pkg::FIFO_PTR_W-1:0] p
  );
    if (p == cbi_pkg::FIFO_PTR_W'(cbi_pkg::FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + cbi_pkg::FIFO_PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + cbi_pkg::FIFO_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - cbi_pkg::FIFO_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

// ----- src/convolutional_byte_interleaver_top.sv -----
// Convolutional byte interleaver, top level. Instantiates cbi_addr_gen, cbi_store and
// cbi_out_fifo; uses cbi_pkg.
// Takes one byte per cycle while input ready is high, a rate set by the single read-first
// RAM port, which reads and writes one slot per item; each accepted byte is registered in
// the RAM read stage, then written to the output queue. Branch j delays its
// bytes by j*UNIT_DEPTH visits; branch zero bypasses the RAM. The RAM holds
// UNIT_DEPTH*BRANCHES*(BRANCHES-1)/2 bytes (792 by default) and is not cleared: per-branch
// fill flags return zeros until a branch has wrapped once, so no clearing pass follows
// reset and items are taken from the first cycle. A three-entry output queue absorbs
// output stalls; input ready drops while the queue and the RAM stage together hold
// three items.
module convolutional_byte_interleaver_top #(
  parameter int unsigned BRANCHES   = cbi_pkg::BRANCHES_DEF,
  parameter int unsigned UNIT_DEPTH = cbi_pkg::UNIT_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cbi_pkg::DATA_W-1:0]   data_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cbi_pkg::DATA_W-1:0]   data_out_o
);

  localparam int unsigned STORE_DEPTH = UNIT_DEPTH * BRANCHES * (BRANCHES - 1) / 2;
  localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned LEN_W       = $clog2((BRANCHES - 1) * UNIT_DEPTH + 1);

  logic              accept;
  logic [ADDR_W-1:0] addr;
  cbi_pkg::cbi_req_t req;
  cbi_pkg::byte_t    rdata;

  logic              s1_valid_q;
  cbi_pkg::cbi_req_t s1_req_q;
  cbi_pkg::byte_t    s1_byte_q;
  cbi_pkg::byte_t    s1_result;

  logic [cbi_pkg::FIFO_CNT_W-1:0] fifo_cnt;
  logic                           pop;

  assign accept = in_valid_i & in_ready_o;
  assign pop    = out_valid_o & out_ready_i;
  assign in_ready_o = (({1'b0, fifo_cnt}) + {{cbi_pkg::FIFO_CNT_W{1'b0}}, s1_valid_q})
                      < (cbi_pkg::FIFO_CNT_W + 1)'(cbi_pkg::FIFO_DEPTH);

  cbi_addr_gen #(
    .BRANCHES  (BRANCHES),
    .UNIT_DEPTH(UNIT_DEPTH),
    .ADDR_W    (ADDR_W),
    .LEN_W     (LEN_W)
  ) u_addr_gen (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(accept),
    .addr_o(addr),
    .req_o (req)
  );

  cbi_store #(
    .DEPTH (STORE_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (accept & ~req.bypass),
    .addr_i (addr),
    .wdata_i(data_in_i),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q  <= req;
      s1_byte_q <= data_in_i;
    end
  end

  always_comb begin
    priority if (s1_req_q.bypass) begin
      s1_result = s1_byte_q;
    end else if (s1_req_q.zero) begin
      s1_result = '0;
    end else begin
      s1_result = rdata;
    end
  end

  cbi_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s1_valid_q),
    .data_i (s1_result),
    .pop_i  (pop),
    .valid_o(out_valid_o),
    .data_o (data_out_o),
    .count_o(fifo_cnt)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (fifo_cnt < cbi_pkg::FIFO_CNT_W'(cbi_pkg::FIFO_DEPTH) || pop))
    else $error("output queue overflow");

  a_bypass_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req.bypass) |=> (s1_result == $past(data_in_i)))
    else $error("branch zero item not passed through");

  a_zero_on_unfilled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !req.bypass && req.zero) |=> (s1_result == '0))
    else $error("unwritten slot did not read as zero");

endmodule
